FILE: rtl/received_line_queue_macros.svh
// assertion macros for the received line queue
`ifndef RECEIVED_LINE_QUEUE_MACROS_SVH
`define RECEIVED_LINE_QUEUE_MACROS_SVH

// same-cycle implication, checked outside reset
`define RLQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RLQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rlq_pkg.sv
// constants, codes and helpers for the received line queue
`default_nettype none
package rlq_pkg;

  // ring geometry
  localparam int LINE_SLOTS  = 8;
  localparam int LINE_BYTES  = 32;
  localparam int SLOT_W      = $clog2(LINE_SLOTS);
  localparam int LEN_W       = $clog2(LINE_BYTES + 1);
  localparam int STORE_DEPTH = LINE_SLOTS * LINE_BYTES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // input modes
  localparam logic MODE_RX    = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_LINE = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  // special characters
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_CR  = 8'h0D;

  // saturation limit of the pending line count
  localparam logic [7:0] PEND_MAX = 8'hFF;

  // next slot round the ring
  function automatic slot_t slot_inc(input slot_t s);
    slot_t r;
    if (s == slot_t'(LINE_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + slot_t'(1);
    end
    return r;
  endfunction

  // first store address of a slot
  function automatic addr_t slot_base(input slot_t s);
    return addr_t'(addr_t'(s) * addr_t'(LINE_BYTES));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/received_line_queue.sv
// received line queue: byte collection into line slots and line fetch
//
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+--------------------------------------
// input    | in        | start & !busy      | in_mode, in_rx_byte
// result   | out       | out_strobe (1 cyc) | out_byte, out_byte_valid, out_last,
//          |           |                    | out_status, out_pending_count
//
// a received byte, a fetch with no pending line and a fetch of an empty line each give
// one word, which appears on the result ports in the cycle after acceptance
// a fetch of an n-byte line streams n words, one per cycle, set by the single read
// port of the line store; busy stays high up to and including the issue of the last byte read
// synchronous active-low reset clears all control state; no clearing pass is needed
// the receiver cannot stall: every word is shown for exactly one cycle
`default_nettype none
`include "received_line_queue_macros.svh"

module received_line_queue
  import rlq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_mode,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_strobe,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_last,
  output logic [1:0]      out_status,
  output logic [7:0]      out_pending_count
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_FETCH = 1'b1;

  // control state
  logic       state_r, state_nxt;
  slot_t      wslot_r, wslot_nxt;
  len_t       wpos_r, wpos_nxt;
  slot_t      rslot_r, rslot_nxt;
  logic [7:0] pend_r, pend_nxt;
  len_t       len_r [LINE_SLOTS];
  logic       ctl_str_r, ctl_str_nxt;
  logic       rd_pend_r, rd_pend_nxt;

  // payload registers
  logic [1:0] ctl_status_r, ctl_status_nxt;
  logic       rd_last_r, rd_last_nxt;
  len_t       idx_r, idx_nxt;
  len_t       flen_r, flen_nxt;
  addr_t      base_r, base_nxt;
  logic [7:0] q_r;

  // line store
  logic [7:0] store_mem [STORE_DEPTH];

  logic  acc;
  logic  we;
  logic  len_we;
  logic  rd_en;
  addr_t wr_addr;
  addr_t rd_addr;
  addr_t base_now;
  len_t  len_sel;

  assign acc      = start & ~busy;
  assign busy     = (state_r == S_FETCH);
  assign len_sel  = len_r[rslot_r];
  assign base_now = slot_base(rslot_r);
  assign wr_addr  = addr_t'(slot_base(wslot_r) + addr_t'(wpos_r));

  // next state of the collector and the fetch sequencer
  always_comb begin
    state_nxt      = state_r;
    wslot_nxt      = wslot_r;
    wpos_nxt       = wpos_r;
    rslot_nxt      = rslot_r;
    pend_nxt       = pend_r;
    ctl_str_nxt    = 1'b0;
    ctl_status_nxt = ST_OK;
    rd_pend_nxt    = 1'b0;
    rd_last_nxt    = 1'b0;
    idx_nxt        = idx_r;
    flen_nxt       = flen_r;
    base_nxt       = base_r;
    we             = 1'b0;
    len_we         = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = addr_t'(base_r + addr_t'(idx_r));
    if (state_r == S_FETCH) begin
      // stream the rest of the line
      rd_en       = 1'b1;
      rd_pend_nxt = 1'b1;
      rd_last_nxt = (idx_r + len_t'(1) == flen_r);
      idx_nxt     = idx_r + len_t'(1);
      if (idx_r + len_t'(1) == flen_r) begin
        state_nxt = S_IDLE;
      end
    end else if (acc) begin
      if (in_mode == MODE_RX) begin
        ctl_str_nxt = 1'b1;
        case (in_rx_byte)
          CHAR_NUL: begin
            wpos_nxt = '0;
          end
          CHAR_CR: begin
            len_we    = 1'b1;
            wslot_nxt = slot_inc(wslot_r);
            wpos_nxt  = '0;
            if (pend_r != PEND_MAX) begin
              pend_nxt = pend_r + 8'd1;
            end
          end
          default: begin
            if (wpos_r < len_t'(LINE_BYTES)) begin
              we       = 1'b1;
              wpos_nxt = wpos_r + len_t'(1);
            end else begin
              ctl_status_nxt = ST_DROPPED;
            end
          end
        endcase
      end else if (pend_r == 8'd0) begin
        ctl_str_nxt    = 1'b1;
        ctl_status_nxt = ST_NO_LINE;
      end else begin
        rslot_nxt = slot_inc(rslot_r);
        pend_nxt  = pend_r - 8'd1;
        if (len_sel == '0) begin
          ctl_str_nxt = 1'b1;
        end else begin
          // first byte read issued at acceptance
          rd_en       = 1'b1;
          rd_addr     = base_now;
          rd_pend_nxt = 1'b1;
          rd_last_nxt = (len_sel == len_t'(1));
          idx_nxt     = len_t'(1);
          base_nxt    = base_now;
          flen_nxt    = len_sel;
          if (len_sel != len_t'(1)) begin
            state_nxt = S_FETCH;
          end
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      wslot_r   <= '0;
      wpos_r    <= '0;
      rslot_r   <= '0;
      pend_r    <= '0;
      ctl_str_r <= 1'b0;
      rd_pend_r <= 1'b0;
      for (int i = 0; i < LINE_SLOTS; i++) begin
        len_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      wslot_r   <= wslot_nxt;
      wpos_r    <= wpos_nxt;
      rslot_r   <= rslot_nxt;
      pend_r    <= pend_nxt;
      ctl_str_r <= ctl_str_nxt;
      rd_pend_r <= rd_pend_nxt;
      if (len_we) begin
        len_r[wslot_r] <= wpos_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ctl_status_r <= ctl_status_nxt;
    rd_last_r    <= rd_last_nxt;
    idx_r        <= idx_nxt;
    flen_r       <= flen_nxt;
    base_r       <= base_nxt;
  end

  // line store write port
  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[wr_addr] <= in_rx_byte;
    end
  end

  // line store read port, registered output
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r <= store_mem[rd_addr];
    end
  end

  // result word: streamed byte or single status word
  assign out_strobe        = ctl_str_r | rd_pend_r;
  assign out_byte          = rd_pend_r ? q_r : 8'h00;
  assign out_byte_valid    = rd_pend_r;
  assign out_last          = rd_pend_r ? rd_last_r : 1'b1;
  assign out_status        = rd_pend_r ? ST_OK : ctl_status_r;
  assign out_pending_count = pend_r;

  // checks
  `RLQ_ASSERT_NOW(a_one_source, ctl_str_r, !rd_pend_r, "status word and stream byte collide")
  `RLQ_ASSERT_NEXT(a_fetch_streams, state_r == S_FETCH, rd_pend_r, "fetch cycle gave no byte")
  `RLQ_ASSERT_NOW(a_fetch_index, state_r == S_FETCH, idx_r < flen_r, "fetch index past line end")
  `RLQ_ASSERT_NOW(a_wpos_range, 1'b1, wpos_r <= len_t'(LINE_BYTES), "write position past slot")
  `RLQ_ASSERT_NEXT(a_pend_drop, !(acc && in_mode == MODE_FETCH), pend_r >= $past(pend_r),
                   "pending count fell without a fetch")

endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
// self-checking bench for the received line queue: directed and random byte traffic
module tb;
  import rlq_pkg::*;

  // one result word as the block shows it
  typedef struct packed {
    logic [7:0] ch;
    logic       ch_valid;
    logic       is_last;
    logic [1:0] status;
    logic [7:0] pending;
  } word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       in_mode = MODE_RX;
  logic [7:0] in_rx_byte = CHAR_NUL;
  logic       busy;
  logic       out_strobe;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_last;
  logic [1:0] out_status;
  logic [7:0] out_pending_count;

  // words still owed by the block, oldest first
  word_t       due_words[$];
  word_t       want;
  int unsigned fail_count = 0;
  int unsigned words_sent = 0;
  bit          idle_on = 1'b1;

  // bench copy of the line ring
  logic [7:0]  ring_bytes [STORE_DEPTH];
  int unsigned ring_len [LINE_SLOTS] = '{default: 0};
  int unsigned fill_slot = 0;
  int unsigned fill_pos = 0;
  int unsigned drain_slot = 0;
  int unsigned lines_waiting = 0;

  always #6 clk = ~clk;

  received_line_queue DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_rx_byte        (in_rx_byte),
    .out_strobe        (out_strobe),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_last          (out_last),
    .out_status        (out_status),
    .out_pending_count (out_pending_count)
  );

  // update the ring copy with one accepted word and queue the words it owes
  function automatic void ring_apply(input logic m, input logic [7:0] b);
    word_t       w;
    int unsigned base;
    int unsigned len;
    w = '{ch: 8'h00, ch_valid: 1'b0, is_last: 1'b1, status: ST_OK, pending: 8'h00};
    if (m == MODE_RX) begin
      if (b == CHAR_NUL) begin
        fill_pos = 0;
      end else if (b == CHAR_CR) begin
        ring_len[fill_slot] = fill_pos;
        fill_slot = (fill_slot + 1) % LINE_SLOTS;
        fill_pos = 0;
        if (lines_waiting < PEND_MAX) begin
          lines_waiting++;
        end
      end else if (fill_pos < LINE_BYTES) begin
        ring_bytes[fill_slot * LINE_BYTES + fill_pos] = b;
        fill_pos++;
      end else begin
        w.status = ST_DROPPED;
      end
      w.pending = 8'(lines_waiting);
      due_words.push_back(w);
    end else if (lines_waiting == 0) begin
      w.status = ST_NO_LINE;
      due_words.push_back(w);
    end else begin
      base = drain_slot * LINE_BYTES;
      len = ring_len[drain_slot];
      drain_slot = (drain_slot + 1) % LINE_SLOTS;
      lines_waiting--;
      w.pending = 8'(lines_waiting);
      if (len == 0) begin
        due_words.push_back(w);
      end else begin
        for (int i = 0; i < len; i++) begin
          w.ch = ring_bytes[base + i];
          w.ch_valid = 1'b1;
          w.is_last = (i + 1 == len);
          due_words.push_back(w);
        end
      end
    end
  endfunction

  // line character other than the terminator and the discard byte
  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255, 1));
    end while (c == CHAR_CR);
    return c;
  endfunction

  function automatic void match_field(input string fname, input logic [7:0] exp_v,
                                      input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", fname, exp_v, got_v);
      fail_count++;
    end
  endfunction

  // offer one word, with random gaps, and wait for it to be taken
  task automatic send_word(input logic m, input logic [7:0] b);
    while (idle_on && $urandom_range(99, 0) < 16) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_mode    <= m;
    in_rx_byte <= b;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
    ring_apply(m, b);
    words_sent++;
  endtask

  task automatic send_line(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      send_word(MODE_RX, rand_char());
    end
    send_word(MODE_RX, CHAR_CR);
  endtask

  // hold the sender off until every owed word has come back
  task automatic pause_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (due_words.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_fetch_with_nothing_pending();
    send_word(MODE_FETCH, 8'h00);
    send_word(MODE_FETCH, 8'hFF);
  endtask

  task automatic test_short_lines();
    // extreme byte values in one line
    send_word(MODE_RX, 8'hFF);
    send_word(MODE_RX, 8'h01);
    send_word(MODE_RX, 8'h80);
    send_word(MODE_RX, CHAR_CR);
    send_word(MODE_FETCH, 8'h00);
    // empty line
    send_word(MODE_RX, CHAR_CR);
    send_word(MODE_FETCH, 8'h55);
    // discard byte throws the partial line away
    send_word(MODE_RX, 8'h78);
    send_word(MODE_RX, 8'h79);
    send_word(MODE_RX, CHAR_NUL);
    send_word(MODE_RX, 8'h7A);
    send_word(MODE_RX, CHAR_CR);
    send_word(MODE_FETCH, 8'h00);
  endtask

  task automatic test_full_slot();
    // two bytes past the slot are dropped, the terminator still closes it
    for (int i = 0; i < LINE_BYTES + 2; i++) begin
      send_word(MODE_RX, rand_char());
    end
    send_word(MODE_RX, CHAR_CR);
    send_word(MODE_FETCH, 8'h00);
  endtask

  task automatic test_ring_overrun();
    // more closed lines than slots, oldest ones overwritten
    for (int i = 0; i < LINE_SLOTS + 2; i++) begin
      send_line(1);
    end
    send_word(MODE_FETCH, 8'h00);
    send_word(MODE_FETCH, 8'h00);
    send_word(MODE_FETCH, 8'h00);
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned len;
    int unsigned pick;
    goal = words_sent + 145;
    while (words_sent < goal) begin
      // quiet stretch with no sender gaps in the middle
      idle_on = !(words_sent + 120 > goal && words_sent + 50 < goal);
      pick = $urandom_range(99, 0);
      if (pick < 55) begin
        // mostly short lines, now and then a long one near or past the slot size
        if ($urandom_range(9, 0) == 0) begin
          len = $urandom_range(LINE_BYTES + 4, LINE_BYTES - 2);
        end else begin
          len = $urandom_range(6, 0);
        end
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(19, 0) == 0) begin
            send_word(MODE_RX, CHAR_NUL);
          end
          send_word(MODE_RX, rand_char());
        end
        if ($urandom_range(9, 0) != 0) begin
          send_word(MODE_RX, CHAR_CR);
        end
      end else if (pick < 90) begin
        send_word(MODE_FETCH, 8'($urandom_range(255, 0)));
      end else begin
        // noise on both fields
        send_word(logic'($urandom_range(1, 0)), 8'($urandom_range(255, 0)));
      end
    end
    idle_on = 1'b1;
  endtask

  // compare each result word with the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      if (due_words.size() == 0) begin
        $error("result word with none owed: out_byte %0h", out_byte);
        fail_count++;
      end else begin
        want = due_words.pop_front();
        match_field("out_byte", want.ch, out_byte);
        match_field("out_byte_valid", 8'(want.ch_valid), 8'(out_byte_valid));
        match_field("out_last", 8'(want.is_last), 8'(out_last));
        match_field("out_status", 8'(want.status), 8'(out_status));
        match_field("out_pending_count", want.pending, out_pending_count);
      end
    end
  end

  // test sequence
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_fetch_with_nothing_pending();
    test_short_lines();
    pause_until_drained();
    test_full_slot();
    pause_until_drained();
    test_ring_overrun();
    test_random_traffic();
    pause_until_drained();
    repeat (LINE_BYTES + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/rlq_pkg.sv
rtl/received_line_queue.sv
bench/tb.sv
